// ===== hw/rtl/pla_pkg.sv =====
// Shared constants and register codes for the point light attenuation block.
`default_nettype none

package pla_pkg;

	typedef enum logic [2:0] {
		REG_LIGHT_POS = 3'd0,
		REG_SPOT_DIR  = 3'd1,
		REG_SPOT_EN   = 3'd2,
		REG_ATT_CONST = 3'd3,
		REG_ATT_LIN   = 3'd4,
		REG_ATT_QUAD  = 3'd5,
		REG_COLOUR    = 3'd6
	} cfg_idx_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// Q8.24 coefficient resets
	localparam logic [31:0] ATT_CONST_RST = 32'd16777216;
	localparam logic [31:0] ATT_LIN_RST   = 32'd117441;
	localparam logic [31:0] ATT_QUAD_RST  = 32'd3355;

	localparam int          LIT_BITS = 30;
	localparam int          DEN_W    = 63;
	localparam logic [63:0] DEN_CAP  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] SPOT_ONE = 64'h0000_0000_0004_0000;
	localparam int          QUO_BITS = LIT_BITS - 1;

	localparam logic [LIT_BITS-1:0] LIT_MAX = {1'b0, {(LIT_BITS-1){1'b1}}};
	localparam logic [LIT_BITS-1:0] LIT_MIN = {1'b1, {(LIT_BITS-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hw/rtl/point_light_attenuation_top.sv =====
// Point/spot light attenuation pipeline: light vector, distance, attenuation, lit colour.
// Throughput: one word per cycle when the output is not stalled; the depth is set by the
// one-bit-per-stage square root and the one-bit-per-stage restoring divider (29 stages,
// four channel lanes).
// Reset: arst_n clears valid bits and loads the register defaults (point light).
// A stalled output freezes the pipe; the first stage still fills while it is empty.
`default_nettype none

module point_light_attenuation_top #(
	parameter int COORD_WIDTH = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// point_x, point_y, point_z
	input  wire  [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// dir_x, dir_y, dir_z, lit_red, lit_green, lit_blue, lit_alpha
	output logic [((3*(COORD_WIDTH+1)+4*30+7)/8)*8-1:0] m_tdata,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [pla_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [pla_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int W    = COORD_WIDTH;
	localparam int ODW  = ((3*(W+1)+4*30+7)/8)*8;
	localparam int SH   = (W > 16) ? W - 16 : 0;
	localparam int VW   = W + 1;
	localparam int DV   = 3 * VW;
	localparam int AW   = VW - SH;
	localparam int SQW  = 2 * AW;
	localparam int SW   = SQW + 2;
	localparam int RW   = SW + 8;
	localparam int RB   = RW / 2;
	localparam int RMW  = RB + 2;
	localparam int PW   = VW + 16;
	localparam int DTW  = PW + 2;
	localparam int SPW  = W + 20;
	localparam int PL   = 32 + RB + SH;
	localparam int LW   = PL - 8;
	localparam int XLW  = (LW > 64) ? LW : 64;
	localparam int PQ   = 32 + SW;
	localparam int QW   = PQ + 2*SH - 8;
	localparam int XQW  = (QW > 64) ? QW : 64;
	localparam int MCW  = 16 + SPW;
	localparam int NW   = MCW + 6;
	localparam int DENW = pla_pkg::DEN_W;
	localparam int QB   = pla_pkg::QUO_BITS;
	localparam int LITW = pla_pkg::LIT_BITS;
	localparam int ZW   = (NW > DENW + QB) ? NW : DENW + QB;
	localparam int LQW  = (3*W < 64) ? 3*W : 64;
	localparam int LXW  = 3*W + 64;
	localparam int RSW  = DV + SPW + 1 + SW;
	localparam int DSW  = DV + 1 + DENW;
	localparam int NS   = RB + 37;

	// configuration registers
	logic [LQW-1:0] lp_q;
	logic [47:0]    sd_q;
	logic           se_q;
	logic [31:0]    kc_q, kl_q, kq_q;
	logic [63:0]    col_q;
	logic [LXW-1:0] lp_ext;

	assign cfg_ready = 1'b1;
	assign lp_ext = LXW'(lp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			sd_q  <= '0;
			se_q  <= 1'b0;
			kc_q  <= pla_pkg::ATT_CONST_RST;
			kl_q  <= pla_pkg::ATT_LIN_RST;
			kq_q  <= pla_pkg::ATT_QUAD_RST;
			col_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pla_pkg::cfg_idx_t'(cfg_index))
				pla_pkg::REG_LIGHT_POS: lp_q  <= cfg_data[LQW-1:0];
				pla_pkg::REG_SPOT_DIR:  sd_q  <= cfg_data[47:0];
				pla_pkg::REG_SPOT_EN:   se_q  <= cfg_data[0];
				pla_pkg::REG_ATT_CONST: kc_q  <= cfg_data[31:0];
				pla_pkg::REG_ATT_LIN:   kl_q  <= cfg_data[31:0];
				pla_pkg::REG_ATT_QUAD:  kq_q  <= cfg_data[31:0];
				pla_pkg::REG_COLOUR:    col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic [NS-1:0] vld_q;
	logic          en, en1, in_acc;

	assign en       = !vld_q[NS-1] || m_tready;
	assign en1      = en || !vld_q[0];
	assign s_tready = en1;
	assign in_acc   = s_tvalid && en1;
	assign m_tvalid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_acc};
		end else if (en1) begin
			vld_q[0] <= in_acc;
		end
	end

	// s1: light minus point
	logic signed [VW-1:0] v_s1 [3];

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < 3; k++) begin
				v_s1[k] <= $signed({lp_ext[k*W+W-1], lp_ext[k*W +: W]})
				         - $signed({s_tdata[k*W+W-1], s_tdata[k*W +: W]});
			end
		end
	end

	// s2: squares of magnitudes, dot products with the spot direction
	logic signed [VW-1:0] v_s2 [3];
	logic [SQW-1:0]       sq_s2 [3];
	logic signed [PW-1:0] prod_s2 [3];
	logic [VW-1:0]        amag [3];
	logic [AW-1:0]        ash [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			amag[k] = v_s1[k][VW-1] ? VW'(-v_s1[k]) : VW'(v_s1[k]);
			ash[k]  = AW'(amag[k] >> SH);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				v_s2[k]    <= v_s1[k];
				sq_s2[k]   <= SQW'(ash[k]) * SQW'(ash[k]);
				prod_s2[k] <= PW'(v_s1[k]) * PW'($signed(sd_q[16*k +: 16]));
			end
		end
	end

	// s3 (root stage 0): sum of squares, spot factor
	logic [RW-1:0]  rt_rad_s  [RB+1];
	logic [RMW-1:0] rt_rem_s  [RB+1];
	logic [RB-1:0]  rt_root_s [RB+1];
	logic [RSW-1:0] rt_side_s [RB+1];

	logic [SW-1:0]         sum3;
	logic signed [DTW-1:0] dot3;
	logic signed [SPW-1:0] spot3;
	logic [SPW-1:0]        smag3;

	always_comb begin
		sum3  = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		dot3  = DTW'(prod_s2[0]) + DTW'(prod_s2[1]) + DTW'(prod_s2[2]);
		spot3 = se_q ? $signed(SPW'(pla_pkg::SPOT_ONE)) - SPW'(dot3)
		             : $signed(SPW'(pla_pkg::SPOT_ONE));
		smag3 = spot3[SPW-1] ? SPW'(-spot3) : SPW'(spot3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rad_s[0]  <= {sum3, 8'd0};
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			rt_side_s[0] <= {v_s2[2], v_s2[1], v_s2[0], smag3, spot3[SPW-1], sum3};
		end
	end

	// square root, one result bit per stage
	for (genvar j = 0; j < RB; j++) begin : g_root
		logic [RMW-1:0] nxt, trial;
		logic           ge;

		always_comb begin
			nxt   = {rt_rem_s[j][RMW-3:0], rt_rad_s[j][RW-1 -: 2]};
			trial = {rt_root_s[j], 2'b01};
			ge    = nxt >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rad_s[j+1]  <= rt_rad_s[j] << 2;
				rt_rem_s[j+1]  <= ge ? nxt - trial : nxt;
				rt_root_s[j+1] <= {rt_root_s[j][RB-2:0], ge};
				rt_side_s[j+1] <= rt_side_s[j];
			end
		end
	end

	// s4: coefficient and colour products
	logic [PL-1:0]  ml_s4;
	logic [PQ-1:0]  mq_s4;
	logic [MCW-1:0] mc_s4 [4];
	logic [DV:0]    side_s4;
	logic [RB+SH-1:0] dist4;
	logic [SW-1:0]  sum4;
	logic [SPW-1:0] smag4;

	always_comb begin
		dist4 = (RB+SH)'(rt_root_s[RB]) << SH;
		sum4  = rt_side_s[RB][SW-1:0];
		smag4 = rt_side_s[RB][SW+1 +: SPW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ml_s4 <= PL'(kl_q) * PL'(dist4);
			mq_s4 <= PQ'(kq_q) * PQ'(sum4);
			for (int c = 0; c < 4; c++) begin
				mc_s4[c] <= MCW'(col_q[16*c +: 16]) * MCW'(smag4);
			end
			side_s4 <= {rt_side_s[RB][SW+1+SPW +: DV], rt_side_s[RB][SW]};
		end
	end

	// s5: scaled, saturated linear and quadratic terms
	logic [DENW-1:0] tl_s5, tq_s5;
	logic [NW-1:0]   n_s5 [4];
	logic [DV:0]     side_s5;
	logic [XLW-1:0]  tl_x;
	logic [XQW-1:0]  tq_x;

	always_comb begin
		tl_x = XLW'(LW'(ml_s4 >> 8));
		tq_x = XQW'(QW'(((PQ+2*SH)'(mq_s4) << (2*SH)) >> 8));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s5 <= (tl_x > XLW'(pla_pkg::DEN_CAP)) ? DENW'(pla_pkg::DEN_CAP) : DENW'(tl_x);
			tq_s5 <= (tq_x > XQW'(pla_pkg::DEN_CAP)) ? DENW'(pla_pkg::DEN_CAP) : DENW'(tq_x);
			for (int c = 0; c < 4; c++) begin
				n_s5[c] <= NW'(mc_s4[c]) << 6;
			end
			side_s5 <= side_s4;
		end
	end

	// s6: denominator
	logic [DENW-1:0] den_s6;
	logic [NW-1:0]   n_s6 [4];
	logic [DV:0]     side_s6;
	logic [63:0]     den_sum;

	assign den_sum = 64'(kc_q) + 64'(tl_s5) + 64'(tq_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= (den_sum > pla_pkg::DEN_CAP) ? DENW'(pla_pkg::DEN_CAP) : DENW'(den_sum);
			n_s6    <= n_s5;
			side_s6 <= side_s5;
		end
	end

	// divider: stage 0 sorts out zero and overflow, then one quotient bit per stage
	logic [ZW-1:0]  dv_rem_s  [QB+1][4];
	logic [QB-1:0]  dv_q_s    [QB+1][4];
	logic [3:0]     dv_zero_s [QB+1];
	logic [3:0]     dv_sat_s  [QB+1];
	logic [DSW-1:0] dv_side_s [QB+1];

	logic [3:0] zero6, sat6;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			zero6[c] = n_s6[c] == '0;
			sat6[c]  = !zero6[c] && (ZW'(n_s6[c]) >= (ZW'(den_s6) << QB));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				dv_rem_s[0][c] <= ZW'(n_s6[c]);
				dv_q_s[0][c]   <= '0;
			end
			dv_zero_s[0] <= zero6;
			dv_sat_s[0]  <= sat6;
			dv_side_s[0] <= {side_s6, den_s6};
		end
	end

	for (genvar t = 0; t < QB; t++) begin : g_div
		localparam int BI = QB - 1 - t;
		logic [ZW-1:0] dsh;
		logic [3:0]    ge;
		logic [QB-1:0] qn [4];

		always_comb begin
			dsh = ZW'(dv_side_s[t][DENW-1:0]) << BI;
			for (int c = 0; c < 4; c++) begin
				ge[c]     = dv_rem_s[t][c] >= dsh;
				qn[c]     = dv_q_s[t][c];
				qn[c][BI] = ge[c];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 4; c++) begin
					dv_rem_s[t+1][c] <= ge[c] ? dv_rem_s[t][c] - dsh : dv_rem_s[t][c];
					dv_q_s[t+1][c]   <= qn[c];
				end
				dv_zero_s[t+1] <= dv_zero_s[t];
				dv_sat_s[t+1]  <= dv_sat_s[t];
				dv_side_s[t+1] <= dv_side_s[t];
			end
		end
	end

	// output word
	logic            neg_o;
	logic [LITW-1:0] lit_o [4];

	always_comb begin
		neg_o = dv_side_s[QB][DENW];
		for (int c = 0; c < 4; c++) begin
			if (dv_sat_s[QB][c]) begin
				lit_o[c] = neg_o ? pla_pkg::LIT_MIN : pla_pkg::LIT_MAX;
			end else if (dv_zero_s[QB][c]) begin
				lit_o[c] = '0;
			end else begin
				lit_o[c] = neg_o ? LITW'(-LITW'(dv_q_s[QB][c])) : LITW'(dv_q_s[QB][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= ODW'({lit_o[3], lit_o[2], lit_o[1], lit_o[0],
			                 dv_side_s[QB][DENW+1 +: DV]});
		end
	end

	// checks
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q[NS-1:1]))
		else $error("pipeline moved during output stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_idle_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(en1 && !s_tvalid) |=> !vld_q[0])
		else $error("first stage valid without an accepted word");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS-2] |-> ((dv_zero_s[QB] & dv_sat_s[QB]) == 4'd0))
		else $error("divider lane flagged both zero and overflow");

endmodule

`default_nettype wire
